// File: hw/rtl/psfrr_pkg.sv
// Package for the per-source FIFO bank with round-robin drain.
// Holds widths, sizes and the request codes; depends on nothing.
`timescale 1ns / 1ps

package psfrr_pkg;
    localparam int NUM_SOURCES  = 8;
    localparam int MAX_CAPACITY = 256;
    localparam int HANDLE_WIDTH = 32;
    localparam int SRC_W        = 3;
    localparam int SEL_W        = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int PTR_W        = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int OCC_W        = $clog2(MAX_CAPACITY + 1);
    localparam int CAP_W        = 9;
    localparam int CNT_W        = 32;
    localparam int ADDR_W       = SEL_W + PTR_W;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(128);

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_PULL = 1'b1;
endpackage

// File: hw/rtl/psfrr_slot_ram.sv
// Slot store for all source FIFOs: one write port, one registered read port.
// Depends on psfrr_pkg for the address and data widths.
`timescale 1ns / 1ps

module psfrr_slot_ram (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [psfrr_pkg::ADDR_W-1:0]       i_waddr,
    input  logic [psfrr_pkg::HANDLE_WIDTH-1:0] i_wdata,
    input  logic                               i_re,
    input  logic [psfrr_pkg::ADDR_W-1:0]       i_raddr,
    output logic [psfrr_pkg::HANDLE_WIDTH-1:0] o_rdata
);
    import psfrr_pkg::*;

    logic [HANDLE_WIDTH-1:0] mem [0:(1<<ADDR_W)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

// File: hw/rtl/per_source_fifo_round_robin_drain_unit.sv
// Top level of the per-source FIFO bank with round-robin drain.
// Depends on psfrr_pkg and psfrr_slot_ram.
`timescale 1ns / 1ps

// Channel   Direction  Handshake        Carries
// request   in         i_valid/o_stall  req_type, source_cpu, packet_handle
// result    out        o_valid/i_stall  handle_valid, out_handle, out_source,
//                                       was_dropped, drop_count
// config    in         i_cfg_valid/o_cfg_ready  capacity
//
// A push decides and writes the slot in ST_IDLE; ST_OUT then posts the result.
// A pull reads the slot RAM in ST_IDLE and takes the registered data in ST_READ.
// Only one request is in flight, so the next request is taken once the result
// register is free. The result register holds while i_stall is high.
// Reset is synchronous and active low; the slot RAM is not cleared, since a
// pull only ever reads slots that a push has written.

module per_source_fifo_round_robin_drain_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_req_type,
    input  logic [psfrr_pkg::SRC_W-1:0]        i_source_cpu,
    input  logic [psfrr_pkg::HANDLE_WIDTH-1:0] i_packet_handle,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_handle_valid,
    output logic [psfrr_pkg::HANDLE_WIDTH-1:0] o_out_handle,
    output logic [psfrr_pkg::SRC_W-1:0]        o_out_source,
    output logic                               o_was_dropped,
    output logic [psfrr_pkg::CNT_W-1:0]        o_drop_count,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [psfrr_pkg::CAP_W-1:0]        i_cfg_data
);
    import psfrr_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_OUT
    } t_state;

    t_state r_state;
    logic [CAP_W-1:0]  r_capacity;
    logic [PTR_W-1:0]  r_head [NUM_SOURCES];
    logic [OCC_W-1:0]  r_occ  [NUM_SOURCES];
    logic [SEL_W-1:0]  r_next_start;
    logic [CNT_W-1:0]  r_drops;
    logic [SEL_W-1:0]  r_sel;
    logic              r_hit;

    logic                    r_valid;
    logic                    r_handle_valid;
    logic [HANDLE_WIDTH-1:0] r_out_handle;
    logic [SRC_W-1:0]        r_out_source;
    logic                    r_was_dropped;

    logic                    accept;
    logic                    ram_we;
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [HANDLE_WIDTH-1:0] ram_rdata;

    // Capacity above the FIFO depth acts as the full depth.
    logic [OCC_W:0]          eff_cap;
    logic                    src_ok;
    logic [SEL_W-1:0]        src_sel;
    logic                    push_fits;
    logic                    found;
    logic [SEL_W-1:0]        pick;
    logic [SEL_W-1:0]        cand;

    assign o_stall     = (r_state != ST_IDLE) || r_valid;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign eff_cap = ({1'b0, r_capacity} > (OCC_W+1)'(MAX_CAPACITY))
                     ? (OCC_W+1)'(MAX_CAPACITY) : (OCC_W+1)'(r_capacity);
    assign src_ok  = 32'(i_source_cpu) < NUM_SOURCES;
    assign src_sel = SEL_W'(i_source_cpu);
    assign push_fits = {1'b0, r_occ[src_sel]} < eff_cap;

    // Round-robin search from the saved start point for a non-empty FIFO.
    always_comb begin
        found = 1'b0;
        pick  = '0;
        cand  = '0;
        for (int k = 0; k < NUM_SOURCES; k++) begin
            cand = SEL_W'((32'(r_next_start) + k) % NUM_SOURCES);
            if (!found && (r_occ[cand] != '0)) begin
                found = 1'b1;
                pick  = cand;
            end
        end
    end

    assign ram_we    = accept && (i_req_type == REQ_PUSH) && src_ok && push_fits;
    assign ram_waddr = {src_sel, PTR_W'(r_head[src_sel] + PTR_W'(r_occ[src_sel]))};
    assign ram_re    = accept && (i_req_type == REQ_PULL) && found;
    assign ram_raddr = {pick, r_head[pick]};

    psfrr_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_packet_handle),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_capacity     <= CAP_RESET;
            r_next_start   <= '0;
            r_drops        <= '0;
            r_valid        <= 1'b0;
            for (int s = 0; s < NUM_SOURCES; s++) begin
                r_head[s] <= '0;
                r_occ[s]  <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_capacity <= i_cfg_data;
            end
            if (r_valid && !i_stall) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_handle_valid <= 1'b0;
                        r_out_handle   <= '0;
                        r_out_source   <= '0;
                        r_was_dropped  <= 1'b0;
                        r_hit          <= 1'b0;
                        if (i_req_type == REQ_PUSH) begin
                            if (src_ok) begin
                                if (push_fits) begin
                                    r_occ[src_sel] <= r_occ[src_sel] + OCC_W'(1);
                                end else begin
                                    r_was_dropped <= 1'b1;
                                    r_drops       <= r_drops + CNT_W'(1);
                                end
                            end
                            r_state <= ST_OUT;
                        end else begin
                            if (found) begin
                                r_hit        <= 1'b1;
                                r_sel        <= pick;
                                r_head[pick] <= r_head[pick] + PTR_W'(1);
                                r_occ[pick]  <= r_occ[pick] - OCC_W'(1);
                                r_next_start <= SEL_W'((32'(pick) + 1) % NUM_SOURCES);
                            end
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    if (r_hit) begin
                        r_handle_valid <= 1'b1;
                        r_out_handle   <= ram_rdata;
                        r_out_source   <= SRC_W'(r_sel);
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    r_valid <= 1'b1;
                    r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid        = r_valid;
    assign o_handle_valid = r_handle_valid;
    assign o_out_handle   = r_out_handle;
    assign o_out_source   = r_out_source;
    assign o_was_dropped  = r_was_dropped;
    assign o_drop_count   = r_drops;
endmodule

// File: hw/rtl/psfrr_checker.sv
// Port-level checker for the FIFO bank, bound to the top level.
// Depends on psfrr_pkg for widths.
`timescale 1ns / 1ps

module psfrr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic                               o_handle_valid,
    input logic [psfrr_pkg::HANDLE_WIDTH-1:0] o_out_handle,
    input logic                               o_was_dropped,
    input logic [psfrr_pkg::CNT_W-1:0]        o_drop_count
);
    import psfrr_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_handle))
        else $error("result changed while stalled");

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_handle_valid && o_was_dropped))
        else $error("pull result marked as dropped");

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("request taken while result pending");

    // Once a request transfer is taken, the block is busy on the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request taken while one is in flight");

    // The drop count only ever steps up by one, wrapping at its width.
    a_drop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(o_drop_count) |-> o_drop_count == $past(o_drop_count) + CNT_W'(1))
        else $error("drop count moved wrongly");
endmodule

bind per_source_fifo_round_robin_drain_unit psfrr_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_handle_valid (o_handle_valid),
    .o_out_handle   (o_out_handle),
    .o_was_dropped  (o_was_dropped),
    .o_drop_count   (o_drop_count)
);

// File: verif/tb_top.sv
// Self-checking testbench for the per-source FIFO bank with round-robin drain.
// Drives pushes and pulls, predicts every result, and compares them in order.
// Depends on psfrr_pkg and per_source_fifo_round_robin_drain_unit.
`timescale 1ns / 1ps

module tb_top;
    import psfrr_pkg::*;

    // One expected result, field for field as the block reports it.
    typedef struct packed {
        logic                    handle_valid;
        logic [HANDLE_WIDTH-1:0] out_handle;
        logic [SRC_W-1:0]        out_source;
        logic                    was_dropped;
        logic [CNT_W-1:0]        drop_count;
    } t_drain_result;

    localparam int CYCLE_LIMIT = 400000;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic                    i_req_type;
    logic [SRC_W-1:0]        i_source_cpu;
    logic [HANDLE_WIDTH-1:0] i_packet_handle;
    logic                    o_valid;
    logic                    i_stall;
    logic                    o_handle_valid;
    logic [HANDLE_WIDTH-1:0] o_out_handle;
    logic [SRC_W-1:0]        o_out_source;
    logic                    o_was_dropped;
    logic [CNT_W-1:0]        o_drop_count;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CAP_W-1:0]        i_cfg_data;

    per_source_fifo_round_robin_drain_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_source_cpu    (i_source_cpu),
        .i_packet_handle (i_packet_handle),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_handle_valid  (o_handle_valid),
        .o_out_handle    (o_out_handle),
        .o_out_source    (o_out_source),
        .o_was_dropped   (o_was_dropped),
        .o_drop_count    (o_drop_count),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    // Predictor state: each source FIFO is kept as a queue of handles, which
    // stands in for the slot ring, head pointer and occupancy of the block.
    logic [HANDLE_WIDTH-1:0] queue_model [NUM_SOURCES][$];
    logic [CAP_W-1:0]        capacity_reg;
    logic [SEL_W-1:0]        scan_start;
    logic [CNT_W-1:0]        drops_seen;
    t_drain_result           pending_results [$];

    int  sender_idle_pct;
    int  receiver_idle_pct;
    int  mismatch_count;
    int  results_checked;
    int  pushes_sent;
    int  pulls_sent;
    int  drops_predicted;
    int  cycle_count = 0;
    bit  timed_out = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The limit is far above the slowest legal run, so only a hang trips it.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAIL per_source_fifo_round_robin_drain_unit");
            $finish;
        end
    end

    // The receiver stall is redrawn every falling edge according to the
    // current idle percentage, so stalls hit every phase of the block.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Each result transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin
        t_drain_result got;
        t_drain_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_handle_valid, o_out_handle, o_out_source, o_was_dropped, o_drop_count};
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result transfer: %p", got);
                end
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Mismatch on result %0d: expected %p, got %p",
                                 results_checked, want, got);
                    end
                end
            end
        end
    end

    // Predict the result of one request and update the model state.
    function automatic t_drain_result predict_request(logic req, logic [SRC_W-1:0] src,
                                                      logic [HANDLE_WIDTH-1:0] handle);
        t_drain_result res;
        int unsigned limit;
        logic [SEL_W-1:0] cur;
        res = '0;
        limit = (capacity_reg > MAX_CAPACITY) ? MAX_CAPACITY : capacity_reg;
        if (req == REQ_PUSH) begin
            if (src < NUM_SOURCES) begin
                if (queue_model[src].size() < limit) begin
                    queue_model[src].push_back(handle);
                end else begin
                    res.was_dropped = 1'b1;
                    drops_seen++;
                    drops_predicted++;
                end
            end
        end else begin
            cur = scan_start;
            for (int k = 0; k < NUM_SOURCES; k++) begin
                if (queue_model[cur].size() != 0) begin
                    res.handle_valid = 1'b1;
                    res.out_handle   = queue_model[cur].pop_front();
                    res.out_source   = cur;
                    scan_start       = cur + 1'b1;
                    break;
                end
                cur = cur + 1'b1;
            end
        end
        res.drop_count = drops_seen;
        return res;
    endfunction

    // Send one request, predicting its result as it is accepted. Valid stays
    // high on return so that the next call can follow back to back; an idle
    // cycle or a drain wait drops it.
    task automatic send_request(logic req, logic [SRC_W-1:0] src, logic [HANDLE_WIDTH-1:0] handle);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_req_type      <= req;
        i_source_cpu    <= src;
        i_packet_handle <= handle;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        pending_results.push_back(predict_request(req, src, handle));
        if (req == REQ_PUSH) pushes_sent++;
        else pulls_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // Capacity writes happen only with the block idle.
    task automatic write_capacity(logic [CAP_W-1:0] value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        capacity_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Push and pull patterns at the extremes: every source, all-ones and zero
    // handles, and pulls of an empty bank.
    task automatic test_directed();
        send_request(REQ_PULL, 3'd5, 32'hFFFF_FFFF);
        for (int s = 0; s < NUM_SOURCES; s++) begin
            send_request(REQ_PUSH, SRC_W'(s), (s % 2) ? 32'hFFFF_FFFF : 32'h0);
        end
        for (int k = 0; k < 9; k++) begin
            send_request(REQ_PULL, 3'd0, 32'h0);
        end
    endtask

    // Capacity zero drops every push; capacity one fills after one handle.
    task automatic test_small_capacity();
        write_capacity(9'd0);
        send_request(REQ_PUSH, 3'd2, 32'hA5A5_5A5A);
        send_request(REQ_PULL, 3'd0, 32'h0);
        write_capacity(9'd1);
        send_request(REQ_PUSH, 3'd7, 32'h1234_5678);
        send_request(REQ_PUSH, 3'd7, 32'h8765_4321);
        send_request(REQ_PULL, 3'd0, 32'h0);
    endtask

    // Capacity lowered below what a FIFO already holds: the extra handles
    // drain normally and new pushes drop until occupancy falls below it.
    task automatic test_lowered_capacity();
        write_capacity(9'd4);
        for (int k = 0; k < 4; k++) begin
            send_request(REQ_PUSH, 3'd3, $urandom);
        end
        write_capacity(9'd2);
        send_request(REQ_PUSH, 3'd3, $urandom);
        send_request(REQ_PULL, 3'd0, 32'h0);
        send_request(REQ_PULL, 3'd0, 32'h0);
        send_request(REQ_PUSH, 3'd3, $urandom);
        send_request(REQ_PULL, 3'd0, 32'h0);
        send_request(REQ_PULL, 3'd0, 32'h0);
        send_request(REQ_PULL, 3'd0, 32'h0);
    endtask

    // Random traffic with a push bias that moves so FIFOs both fill and empty.
    task automatic test_random(int count, int push_pct);
        for (int k = 0; k < count; k++) begin
            send_request(($urandom_range(99) < push_pct) ? REQ_PUSH : REQ_PULL,
                         SRC_W'($urandom_range(NUM_SOURCES - 1)), $urandom);
        end
    endtask

    // Capacity above the maximum is clipped; the largest value is used too.
    task automatic test_capacity_sweep();
        write_capacity(9'd3);
        test_random(250, 60);
        test_random(100, 25);
        write_capacity(9'd511);
        test_random(200, 80);
        write_capacity(9'd256);
        test_random(150, 70);
        test_random(150, 20);
    endtask

    task automatic test_random_phases();
        sender_idle_pct   = 15;
        receiver_idle_pct = 54;
        write_capacity(9'd6);
        test_random(250, 55);
        sender_idle_pct   = 54;
        receiver_idle_pct = 15;
        write_capacity(9'd2);
        test_random(250, 65);
        // Hold the sender until every result is back, then continue.
        wait_drained();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        write_capacity(9'd128);
        test_random(250, 50);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_req_type      = REQ_PUSH;
        i_source_cpu    = '0;
        i_packet_handle = '0;
        i_stall         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        mismatch_count    = 0;
        results_checked   = 0;
        pushes_sent       = 0;
        pulls_sent        = 0;
        drops_predicted   = 0;
        sender_idle_pct   = 15;
        receiver_idle_pct = 54;
        capacity_reg      = CAP_RESET;
        scan_start        = '0;
        drops_seen        = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_small_capacity();
        test_lowered_capacity();
        test_capacity_sweep();
        test_random_phases();

        wait_drained();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d pushes and %0d pulls, %0d predicted drops, %0d results checked.",
                 pushes_sent, pulls_sent, drops_predicted, results_checked);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS per_source_fifo_round_robin_drain_unit");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_results.size());
            $display("FAIL per_source_fifo_round_robin_drain_unit");
        end
        $finish;
    end
endmodule
